>>> hdl/numa_page_node_select_assert.svh
// ----------------------------------------------------------------------------
// numa_page_node_select assertion macros
// Clocked implication checks used by the node selector top level.
// ----------------------------------------------------------------------------
`ifndef NUMA_PAGE_NODE_SELECT_ASSERT_SVH
`define NUMA_PAGE_NODE_SELECT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define NPS_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("nps check failed");

// next-cycle implication, disabled during reset
`define NPS_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("nps check failed");

`endif

>>> hdl/nps_pkg.sv
// ----------------------------------------------------------------------------
// nps_pkg
// Types, codes and constants of the page node selector.
// ----------------------------------------------------------------------------
package nps_pkg;

  localparam int unsigned AddrW     = 64;
  localparam int unsigned PageShift = 12;
  localparam int unsigned PfnW      = AddrW - PageShift;
  localparam int unsigned CellBits  = 4;
  localparam int unsigned NumCells  = PfnW / CellBits;
  localparam int unsigned MaskW     = 16;
  localparam int unsigned NodeW     = 4;
  localparam int unsigned DefMaxNodes = 16;

  typedef enum logic [1:0] {
    ModeAny        = 2'd0,
    ModeBind       = 2'd1,
    ModePreferred  = 2'd2,
    ModeInterleave = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    OutAny       = 2'd0,
    OutStrict    = 2'd1,
    OutPreferred = 2'd2,
    OutFail      = 2'd3
  } outcome_e;

  typedef enum logic [1:0] {
    RegMode   = 2'd0,
    RegTarget = 2'd1,
    RegMask   = 2'd2
  } reg_e;

  typedef struct packed {
    mode_e              mode;
    logic [NodeW-1:0]   target;
    logic [MaskW-1:0]   mask;
  } cfg_t;

endpackage

>>> hdl/nps_mod_cell.sv
// ----------------------------------------------------------------------------
// nps_mod_cell
// One link of the remainder chain: folds four page frame bits into the
// running remainder modulo the node count and hands the beat on.
// ----------------------------------------------------------------------------
module nps_mod_cell #(
  parameter int unsigned RemW = 4,
  parameter int unsigned CntW = 5
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [CntW-1:0]           count_i,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic [nps_pkg::PfnW-1:0]  pfn_i,
  input  logic [RemW-1:0]           rem_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output logic [nps_pkg::PfnW-1:0]  pfn_o,
  output logic [RemW-1:0]           rem_o
);
  import nps_pkg::*;

  logic                valid_q;
  logic [PfnW-1:0]     pfn_q, pfn_d;
  logic [RemW-1:0]     rem_q, rem_d;
  logic                load;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    logic [RemW:0]       t;
    logic [RemW:0]       cnt_ext;
    logic [RemW-1:0]     r;
    logic [CellBits-1:0] dig;
    cnt_ext = (RemW+1)'(count_i);
    dig     = pfn_i[PfnW-1 -: CellBits];
    r       = rem_i;
    for (int k = 0; k < CellBits; k++) begin
      t = {r, dig[CellBits-1-k]};
      if (t >= cnt_ext) begin
        t = t - cnt_ext;
      end
      r = t[RemW-1:0];
    end
    rem_d = r;
    pfn_d = pfn_i << CellBits;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      pfn_q <= pfn_d;
      rem_q <= rem_d;
    end
  end

  assign valid_o = valid_q;
  assign pfn_o   = pfn_q;
  assign rem_o   = rem_q;

endmodule

>>> hdl/nps_select.sv
// ----------------------------------------------------------------------------
// nps_select
// Output stage: maps the remainder to the n-th enabled node, applies the
// policy mode and holds the result beat until it is taken.
// ----------------------------------------------------------------------------
module nps_select #(
  parameter int unsigned Lanes = 16,
  parameter int unsigned RemW  = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  nps_pkg::cfg_t               cfg_i,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  logic [RemW-1:0]             rem_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output nps_pkg::outcome_e           outcome_o,
  output logic [nps_pkg::NodeW-1:0]   node_o
);
  import nps_pkg::*;

  localparam logic [MaskW-1:0] LaneMask = MaskW'((17'd1 << Lanes) - 17'd1);

  logic              valid_q;
  outcome_e          outcome_q, outcome_d;
  logic [NodeW-1:0]  node_q, node_d;
  logic [NodeW-1:0]  pick;
  logic [MaskW-1:0]  lane_mask;

  assign lane_mask = cfg_i.mask & LaneMask;
  assign ready_o   = !valid_q || ready_i;

  always_comb begin
    logic [MaskW-1:0] below;
    pick = '0;
    for (int i = 0; i < Lanes; i++) begin
      below = lane_mask & ((MaskW'(1) << i) - MaskW'(1));
      if (lane_mask[i] && ($countones(below) == int'(rem_i))) begin
        pick = NodeW'(i);
      end
    end
  end

  always_comb begin
    outcome_d = OutAny;
    node_d    = '0;
    case (cfg_i.mode)
      ModeBind: begin
        outcome_d = OutStrict;
        node_d    = cfg_i.target;
      end
      ModePreferred: begin
        outcome_d = OutPreferred;
        node_d    = cfg_i.target;
      end
      ModeInterleave: begin
        if (lane_mask == '0) begin
          outcome_d = OutFail;
        end else begin
          outcome_d = OutStrict;
          node_d    = pick;
        end
      end
      default: begin
        outcome_d = OutAny;
        node_d    = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      outcome_q <= outcome_d;
      node_q    <= node_d;
    end
  end

  assign valid_o   = valid_q;
  assign outcome_o = outcome_q;
  assign node_o    = node_q;

endmodule

>>> hdl/numa_page_node_select.sv
// ----------------------------------------------------------------------------
// numa_page_node_select
// Page placement node selector with bind, preferred and interleave policies.
// ----------------------------------------------------------------------------
// One address beat in and one result beat out per cycle while the receiver
// is ready. The page frame number (address bits 63:12) runs through a
// row of 13 remainder cells, each folding 4 bits into the remainder modulo
// the enabled node count, followed by one output register that picks the
// node and holds the result. Interleave uses mask bits below MAX_NODES (at
// most 16); an empty set yields the fail outcome. Write registers only while
// no beat is in flight.
// ----------------------------------------------------------------------------
module numa_page_node_select #(
  parameter int unsigned MAX_NODES = nps_pkg::DefMaxNodes
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // slave stream; tdata: virt_address[63:0]
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [63:0]  s_axis_tdata_i,
  // master stream; tdata: outcome[1:0], chosen_node[5:2], zero[7:6]
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [7:0]   m_axis_tdata_o,
  // register port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import nps_pkg::*;

  localparam int unsigned Lanes = (MAX_NODES < MaskW) ? MAX_NODES : MaskW;
  localparam int unsigned RemW  = $clog2(Lanes);
  localparam int unsigned CntW  = $clog2(Lanes + 1);

  cfg_t              cfg_q;
  logic              wr_en;
  reg_e              reg_sel;
  logic [CntW-1:0]   node_cnt;

  logic              vld [NumCells+1];
  logic              rdy [NumCells+1];
  logic [PfnW-1:0]   pfn [NumCells+1];
  logic [RemW-1:0]   rem [NumCells+1];

  outcome_e          outcome;
  logic [NodeW-1:0]  node;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        RegMode:   cfg_q.mode   <= mode_e'(pwdata[1:0]);
        RegTarget: cfg_q.target <= pwdata[NodeW-1:0];
        RegMask:   cfg_q.mask   <= pwdata[MaskW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      RegMode:   prdata = 32'(cfg_q.mode);
      RegTarget: prdata = 32'(cfg_q.target);
      RegMask:   prdata = 32'(cfg_q.mask);
      default:   prdata = '0;
    endcase
  end

  assign node_cnt = CntW'($countones(cfg_q.mask[Lanes-1:0]));

  assign vld[0]          = s_axis_tvalid_i;
  assign s_axis_tready_o = rdy[0];
  assign pfn[0]          = s_axis_tdata_i[AddrW-1:PageShift];
  assign rem[0]          = '0;

  for (genvar c = 0; c < NumCells; c++) begin : g_cell
    nps_mod_cell #(
      .RemW (RemW),
      .CntW (CntW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .count_i (node_cnt),
      .valid_i (vld[c]),
      .ready_o (rdy[c]),
      .pfn_i   (pfn[c]),
      .rem_i   (rem[c]),
      .valid_o (vld[c+1]),
      .ready_i (rdy[c+1]),
      .pfn_o   (pfn[c+1]),
      .rem_o   (rem[c+1])
    );
  end

  nps_select #(
    .Lanes (Lanes),
    .RemW  (RemW)
  ) u_select (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .valid_i   (vld[NumCells]),
    .ready_o   (rdy[NumCells]),
    .rem_i     (rem[NumCells]),
    .valid_o   (m_axis_tvalid_o),
    .ready_i   (m_axis_tready_i),
    .outcome_o (outcome),
    .node_o    (node)
  );

  assign m_axis_tdata_o = {2'b00, node, outcome};

`include "numa_page_node_select_assert.svh"

  `NPS_ASSERT_IMP(a_fail_only_empty, m_axis_tvalid_o && outcome == OutFail, cfg_q.mode == ModeInterleave && node_cnt == '0 && node == '0)
  `NPS_ASSERT_IMP(a_any_node_zero, m_axis_tvalid_o && outcome == OutAny, node == '0 && cfg_q.mode == ModeAny)
  `NPS_ASSERT_IMP(a_interleave_enabled, m_axis_tvalid_o && cfg_q.mode == ModeInterleave && outcome == OutStrict, cfg_q.mask[node] && node_cnt != '0)
  `NPS_ASSERT_IMP(a_preferred_target, m_axis_tvalid_o && outcome == OutPreferred, node == cfg_q.target)
  `NPS_ASSERT_NXT(a_entry_taken, s_axis_tvalid_i && s_axis_tready_o, vld[1])

endmodule

>>> verif/numa_page_node_select_test.sv
// ----------------------------------------------------------------------------
// numa_page_node_select_test
// Streams page addresses through the node selector under bind, preferred,
// interleave and default policies. Each accepted address beat is scored
// against a placement predicted from the current policy registers. The
// registers are written and read back over APB while the pipe is empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module numa_page_node_select_test;
  import nps_pkg::*;

  localparam int unsigned MAX_NODES   = 16;
  localparam int unsigned NODE_LIMIT  = (MAX_NODES < MaskW) ? MAX_NODES : MaskW;
  localparam int unsigned CLK_PERIOD  = 20;
  localparam int unsigned LATENCY     = 14;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 250000;

  typedef struct packed {
    outcome_e         outcome;
    logic [NodeW-1:0] node;
  } placement_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i  = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [7:0]  m_axis_tdata_o;
  logic        psel            = 1'b0;
  logic        penable         = 1'b0;
  logic        pwrite          = 1'b0;
  logic [3:0]  paddr           = '0;
  logic [31:0] pwdata          = '0;
  logic [31:0] prdata;
  logic        pready;

  mode_e            cfg_mode   = ModeAny;
  logic [NodeW-1:0] cfg_target = '0;
  logic [MaskW-1:0] cfg_mask   = '0;

  logic [63:0] address_q[$];
  placement_t  placement_q[$];
  bit          addr_fire      = 1'b0;
  bit          hold_req       = 1'b0;
  bit          hold_active    = 1'b0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_idle_pct  = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  numa_page_node_select #(
    .MAX_NODES(MAX_NODES)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic placement_t place_page(input logic [63:0] va);
    placement_t  p;
    int unsigned members;
    int unsigned seen;
    int unsigned pick;
    longint unsigned pfn;
    p.outcome = OutAny;
    p.node    = '0;
    case (cfg_mode)
      ModeBind: begin
        p.outcome = OutStrict;
        p.node    = cfg_target;
      end
      ModePreferred: begin
        p.outcome = OutPreferred;
        p.node    = cfg_target;
      end
      ModeInterleave: begin
        members = 0;
        for (int i = 0; i < NODE_LIMIT; i++) begin
          if (cfg_mask[i]) members++;
        end
        if (members == 0) begin
          p.outcome = OutFail;
        end else begin
          pfn  = va >> PageShift;
          pick = int'(pfn % longint'(members));
          seen = 0;
          for (int i = 0; i < NODE_LIMIT; i++) begin
            if (cfg_mask[i]) begin
              if (seen == pick) p.node = NodeW'(i);
              seen++;
            end
          end
          p.outcome = OutStrict;
        end
      end
      default: ;
    endcase
    return p;
  endfunction

  function automatic logic [63:0] rand_address();
    logic [63:0] va;
    va = {$urandom, $urandom};
    if ($urandom_range(0, 7) == 0) va[63:24] = '0;
    return va;
  endfunction

  // sender: hold the beat until taken, then offer the next or idle
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else if (!s_axis_tvalid_i || addr_fire) begin
      if (address_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        s_axis_tdata_i  <= address_q.pop_front();
        s_axis_tvalid_i <= 1'b1;
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready_i <= rst_ni && !hold_active && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // score result beats first, then record new address beats
  always @(posedge clk_i) begin : score_beats
    placement_t want;
    addr_fire = 1'b0;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (placement_q.size() == 0) begin
          report_mismatch("result beat with no placement pending");
        end else begin
          want = placement_q.pop_front();
          if (m_axis_tdata_o[1:0] != want.outcome)
            report_mismatch($sformatf("outcome %0d, want %0d",
                                      m_axis_tdata_o[1:0], want.outcome));
          if (m_axis_tdata_o[5:2] != want.node)
            report_mismatch($sformatf("chosen_node %0d, want %0d",
                                      m_axis_tdata_o[5:2], want.node));
          if (m_axis_tdata_o[7:6] != 2'b00)
            report_mismatch($sformatf("pad bits %b", m_axis_tdata_o[7:6]));
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        placement_q.push_back(place_page(s_axis_tdata_i));
        addr_fire = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[%0t] timeout", $time);
      $display("numa_page_node_select_test failed");
      $finish;
    end
  end

  // long receiver stall, counted here
  initial begin
    wait (hold_req);
    hold_active = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_active = 1'b0;
  end

  task automatic apb_access(input reg_e idx, input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_reg(input reg_e idx, input logic [31:0] value);
    logic [31:0] readback;
    apb_access(idx, 1'b1, value, readback);
    apb_access(idx, 1'b0, '0, readback);
    if (readback != value)
      report_mismatch($sformatf("register %s reads %0h, want %0h",
                                idx.name(), readback, value));
  endtask

  task automatic set_policy(input mode_e m, input logic [NodeW-1:0] t,
                            input logic [MaskW-1:0] k);
    write_reg(RegMode, 32'(m));
    write_reg(RegTarget, 32'(t));
    write_reg(RegMask, 32'(k));
    cfg_mode   = m;
    cfg_target = t;
    cfg_mask   = k;
  endtask

  task automatic drain();
    while (address_q.size() != 0 || s_axis_tvalid_i || placement_q.size() != 0)
      @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  task automatic random_phase(input int unsigned count);
    mode_e            m;
    logic [MaskW-1:0] k;
    if ($urandom_range(0, 9) < 5) m = ModeInterleave;
    else m = mode_e'($urandom_range(0, 2));
    case ($urandom_range(0, 5))
      0:       k = '0;
      1:       k = '1;
      2:       k = MaskW'(1) << $urandom_range(0, MaskW - 1);
      default: k = MaskW'($urandom);
    endcase
    set_policy(m, NodeW'($urandom), k);
    repeat (count) address_q.push_back(rand_address());
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct = 35;
    recv_idle_pct = 52;

    // default policy
    set_policy(ModeAny, 4'd0, 16'h0000);
    address_q.push_back('0);
    address_q.push_back('1);
    drain();
    // bind
    set_policy(ModeBind, 4'd15, 16'hFFFF);
    address_q.push_back(64'h1234_5678_9ABC_DEF0);
    address_q.push_back('1);
    drain();
    // preferred
    set_policy(ModePreferred, 4'd0, 16'h0000);
    address_q.push_back(64'h0000_0000_0000_0FFF);
    address_q.push_back(64'h0000_0000_0000_1000);
    drain();
    set_policy(ModePreferred, 4'd9, 16'h5A5A);
    address_q.push_back(rand_address());
    drain();
    // interleave over an empty set
    set_policy(ModeInterleave, 4'd7, 16'h0000);
    address_q.push_back('0);
    address_q.push_back('1);
    drain();
    // interleave over all nodes
    set_policy(ModeInterleave, 4'd3, 16'hFFFF);
    address_q.push_back(64'h0);
    address_q.push_back(64'h0000_0000_0000_F000);
    address_q.push_back(64'h0000_0000_0001_0000);
    address_q.push_back('1);
    drain();
    // interleave over the top node only
    set_policy(ModeInterleave, 4'd0, 16'h8000);
    address_q.push_back(64'h0000_0000_0000_5000);
    address_q.push_back('1);
    drain();
    set_policy(ModeInterleave, 4'd0, 16'h8421);
    for (int i = 0; i < 5; i++) address_q.push_back(64'(i) << PageShift);
    drain();
    set_policy(ModeInterleave, 4'd0, 16'h0007);
    address_q.push_back('1);
    address_q.push_back(64'h7FFF_FFFF_FFFF_F000);
    drain();

    for (int regime = 0; regime < 3; regime++) begin
      case (regime)
        0: begin
          send_idle_pct = 35;
          recv_idle_pct = 52;
        end
        1: begin
          send_idle_pct = 52;
          recv_idle_pct = 35;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          hold_req      = 1'b1;
        end
      endcase
      for (int phase = 0; phase < 8; phase++) random_phase(80);
    end

    drain();
    if (mismatch_count == 0) begin
      $display("numa_page_node_select_test passed");
    end else begin
      $display("numa_page_node_select_test failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hdl
hdl/nps_pkg.sv
hdl/nps_mod_cell.sv
hdl/nps_select.sv
hdl/numa_page_node_select.sv
verif/numa_page_node_select_test.sv
